// ----- rtl/core/pott_pkg.sv -----
package pott_pkg;

    // Command codes carried in the mode field.
    localparam logic [2:0] MODE_CLEAR   = 3'd0;
    localparam logic [2:0] MODE_CREATE  = 3'd1;
    localparam logic [2:0] MODE_DESTROY = 3'd2;
    localparam logic [2:0] MODE_RUN     = 3'd3;
    localparam logic [2:0] MODE_FIND    = 3'd4;

    // Run order never emits more beats than this.
    localparam int RUN_MAX = 16;

    // One command beat.
    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  slot;
        logic [15:0] handler;
        logic [7:0]  priority_req;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic [3:0]  result_slot;
        logic [15:0] result_handler;
        logic        ok;
        logic        last;
    } t_res;

endpackage

// ----- rtl/core/priority_ordered_task_table_top.sv -----
// Clear, unused modes and run order on an empty table answer straight from idle; destroy
// unlinks the slot in S_DEL; find compares one slot a cycle, lowest first; run order emits
// one beat per linked slot, up to RUN_LIMIT. Create scans one slot a cycle for a free slot,
// walks the list one slot a cycle, writes in S_LINK_A, then S_LINK_B, then registers its beat.
// Throughput: one command at a time; a new command is taken in the cycle of the final beat.
// Reset (synchronous, active low) empties the table; the receiver cannot stall.
module priority_ordered_task_table_top #(
    parameter int SLOT_COUNT = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pott_pkg::t_cmd i_cmd,
    output logic          o_res_strobe,
    output pott_pkg::t_res o_res
);

    import pott_pkg::*;

    localparam int IW        = $clog2(SLOT_COUNT);
    localparam int RUN_LIMIT = (SLOT_COUNT < RUN_MAX) ? SLOT_COUNT : RUN_MAX;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FREE   = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_LINK_A = 3'd3;
    localparam logic [2:0] S_LINK_B = 3'd4;
    localparam logic [2:0] S_DEL    = 3'd5;
    localparam logic [2:0] S_RUN    = 3'd6;
    localparam logic [2:0] S_FIND   = 3'd7;

    // A link is a slot index with a valid flag; invalid marks head, tail or empty.
    typedef struct packed {
        logic          vld;
        logic [IW-1:0] idx;
    } t_link;

    localparam t_link LINK_NONE = '{vld: 1'b0, idx: '0};

    logic [2:0]            r_state, n_state;
    logic [SLOT_COUNT-1:0] r_active, n_active;
    t_link                 r_head, n_head;
    t_cmd                  r_cmd;
    logic [IW-1:0]         r_cur, n_cur;
    logic [IW-1:0]         r_new, n_new;
    t_link                 r_lp, n_lp;
    t_link                 r_ln, n_ln;
    logic [3:0]            r_cnt, n_cnt;
    t_res                  r_res, n_res;
    logic                  r_res_vld, n_res_vld;

    // Memory ports.
    logic          tag_we, prio_we, prev_we, next_we;
    logic [IW-1:0] tag_waddr, prio_waddr, prev_waddr, next_waddr;
    t_link         prev_wdata, next_wdata;
    logic [15:0]   tag_rd;
    logic [7:0]    prio_rd;
    t_link         prev_rd, next_rd;

    logic          accept;
    logic          slot_ok;
    logic [IW-1:0] slot_idx;

    assign accept   = start && !busy;
    assign slot_idx = IW'(r_cmd.slot);
    assign slot_ok  = (32'(r_cmd.slot) < SLOT_COUNT) && r_active[slot_idx];

    // Field stores; all of them are read at the same index, the next value of r_cur.
    pott_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_cmd.handler),
        .i_raddr (n_cur),
        .o_rdata (tag_rd)
    );

    pott_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (prio_we),
        .i_waddr (prio_waddr),
        .i_wdata (r_cmd.priority_req),
        .i_raddr (n_cur),
        .o_rdata (prio_rd)
    );

    pott_ram #(.WIDTH(IW + 1), .DEPTH(SLOT_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_raddr (n_cur),
        .o_rdata (prev_rd)
    );

    pott_ram #(.WIDTH(IW + 1), .DEPTH(SLOT_COUNT)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (n_cur),
        .o_rdata (next_rd)
    );

    // Sequencer: one slot is visited per cycle.
    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_head     = r_head;
        n_cur      = r_cur;
        n_new      = r_new;
        n_lp       = r_lp;
        n_ln       = r_ln;
        n_cnt      = r_cnt;
        n_res      = r_res;
        n_res_vld  = 1'b0;
        tag_we     = 1'b0;
        prio_we    = 1'b0;
        prev_we    = 1'b0;
        next_we    = 1'b0;
        tag_waddr  = r_new;
        prio_waddr = r_new;
        prev_waddr = r_new;
        next_waddr = r_new;
        prev_wdata = r_lp;
        next_wdata = r_ln;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.mode)
                        MODE_CLEAR: begin
                            n_active  = '0;
                            n_head    = LINK_NONE;
                            n_res     = '{result_slot: 4'd0, result_handler: 16'd0,
                                          ok: 1'b1, last: 1'b1};
                            n_res_vld = 1'b1;
                        end
                        MODE_CREATE: begin
                            n_cur   = '0;
                            n_state = S_FREE;
                        end
                        MODE_DESTROY: begin
                            n_cur   = IW'(i_cmd.slot);
                            n_state = S_DEL;
                        end
                        MODE_RUN: begin
                            if (r_head.vld) begin
                                n_cur   = r_head.idx;
                                n_cnt   = 4'd0;
                                n_state = S_RUN;
                            end else begin
                                n_res     = '{result_slot: 4'd0, result_handler: 16'd0,
                                              ok: 1'b0, last: 1'b1};
                                n_res_vld = 1'b1;
                            end
                        end
                        MODE_FIND: begin
                            n_cur   = '0;
                            n_state = S_FIND;
                        end
                        default: begin
                            n_res     = '{result_slot: 4'd0, result_handler: 16'd0,
                                          ok: 1'b0, last: 1'b1};
                            n_res_vld = 1'b1;
                        end
                    endcase
                end
            end

            // Scan for the lowest free slot.
            S_FREE: begin
                if (!r_active[r_cur]) begin
                    n_new = r_cur;
                    if (r_head.vld) begin
                        n_cur   = r_head.idx;
                        n_state = S_WALK;
                    end else begin
                        n_lp    = LINK_NONE;
                        n_ln    = LINK_NONE;
                        n_state = S_LINK_A;
                    end
                end else if (r_cur == IW'(SLOT_COUNT - 1)) begin
                    n_res     = '{result_slot: 4'd0, result_handler: 16'd0,
                                  ok: 1'b0, last: 1'b1};
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_cur = r_cur + IW'(1);
                end
            end

            // Walk the list until a strictly greater priority or the tail.
            S_WALK: begin
                if (r_cmd.priority_req < prio_rd) begin
                    n_lp    = prev_rd;
                    n_ln    = '{vld: 1'b1, idx: r_cur};
                    n_state = S_LINK_A;
                end else if (!next_rd.vld) begin
                    n_lp    = '{vld: 1'b1, idx: r_cur};
                    n_ln    = LINK_NONE;
                    n_state = S_LINK_A;
                end else begin
                    n_cur = next_rd.idx;
                end
            end

            // Store the new slot's fields and its own links.
            S_LINK_A: begin
                tag_we  = 1'b1;
                prio_we = 1'b1;
                prev_we = 1'b1;
                next_we = 1'b1;
                n_state = S_LINK_B;
            end

            // Point the neighbors at the new slot.
            S_LINK_B: begin
                prev_waddr = r_ln.idx;
                prev_wdata = '{vld: 1'b1, idx: r_new};
                prev_we    = r_ln.vld;
                next_waddr = r_lp.idx;
                next_wdata = '{vld: 1'b1, idx: r_new};
                next_we    = r_lp.vld;
                if (!r_lp.vld) begin
                    n_head = '{vld: 1'b1, idx: r_new};
                end
                n_active[r_new] = 1'b1;
                n_res     = '{result_slot: 4'(r_new), result_handler: r_cmd.handler,
                              ok: 1'b1, last: 1'b1};
                n_res_vld = 1'b1;
                n_state   = S_IDLE;
            end

            // Unlink the slot; its links are on the read ports now.
            S_DEL: begin
                if (slot_ok) begin
                    next_waddr = prev_rd.idx;
                    next_wdata = next_rd;
                    next_we    = prev_rd.vld;
                    prev_waddr = next_rd.idx;
                    prev_wdata = prev_rd;
                    prev_we    = next_rd.vld;
                    if (!prev_rd.vld) begin
                        n_head = next_rd;
                    end
                    n_active[slot_idx] = 1'b0;
                    n_res = '{result_slot: r_cmd.slot, result_handler: tag_rd,
                              ok: 1'b1, last: 1'b1};
                end else begin
                    n_res = '{result_slot: r_cmd.slot, result_handler: 16'd0,
                              ok: 1'b0, last: 1'b1};
                end
                n_res_vld = 1'b1;
                n_state   = S_IDLE;
            end

            // Emit one beat per linked slot from head to tail, at most RUN_LIMIT beats.
            S_RUN: begin
                n_res_vld = 1'b1;
                if (!next_rd.vld || r_cnt == 4'(RUN_LIMIT - 1)) begin
                    n_res   = '{result_slot: 4'(r_cur), result_handler: tag_rd,
                                ok: 1'b1, last: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    n_res = '{result_slot: 4'(r_cur), result_handler: tag_rd,
                              ok: 1'b1, last: 1'b0};
                    n_cur = next_rd.idx;
                    n_cnt = r_cnt + 4'd1;
                end
            end

            // Compare one stored tag per cycle, lowest slot first.
            S_FIND: begin
                if (r_active[r_cur] && tag_rd == r_cmd.handler) begin
                    n_res     = '{result_slot: 4'(r_cur), result_handler: r_cmd.handler,
                                  ok: 1'b1, last: 1'b1};
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_cur == IW'(SLOT_COUNT - 1)) begin
                    n_res     = '{result_slot: 4'd0, result_handler: 16'd0,
                                  ok: 1'b0, last: 1'b1};
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_cur = r_cur + IW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_head    <= LINK_NONE;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_head    <= n_head;
            r_res_vld <= n_res_vld;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_cur <= n_cur;
        r_new <= n_new;
        r_lp  <= n_lp;
        r_ln  <= n_ln;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_res_strobe = r_res_vld;
    assign o_res        = r_res;

    // A beat that is not the last is always followed by another beat.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_res.last |=> o_res_strobe)
        else $error("run order stopped before its last beat");

    // The final beat of a command leaves the block free for the next one.
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.last |-> !busy)
        else $error("block still busy at the final beat");

    // An accepted command is either being worked on or already answered.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_res_strobe)
        else $error("accepted command produced no activity");

    // The head of the list always names an active slot.
    a_head_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head.vld |-> r_active[r_head.idx])
        else $error("list head points at an inactive slot");

endmodule

// ----- rtl/core/pott_ram.sv -----
module pott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/priority_ordered_task_table_top_tb.sv -----
module priority_ordered_task_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pott_pkg::*;

    localparam int NSLOTS = 16;
    localparam int RANDOM_CMDS = 450;
    localparam int DRAIN_CYCLES = 40;

    // Link markers used by the task list.
    localparam logic [7:0] HEAD_MARK  = 8'hFE;
    localparam logic [7:0] TAIL_MARK  = 8'hFF;
    localparam logic [7:0] EMPTY_MARK = 8'hFF;

    // Mode codes the block does not implement.
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_cmd i_cmd = '0;
    logic o_res_strobe;
    t_res o_res;

    priority_ordered_task_table_top #(
        .SLOT_COUNT(NSLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shadow copy of the task table.
    logic       tbl_active [NSLOTS];
    logic [15:0] tbl_tag   [NSLOTS];
    logic [7:0] tbl_prio   [NSLOTS];
    logic [7:0] tbl_prev   [NSLOTS];
    logic [7:0] tbl_next   [NSLOTS];
    logic [7:0] tbl_head;

    t_cmd pending_cmds[$];
    t_res awaited_beats[$];

    int cmds_total = 0;
    int cmds_taken = 0;
    int error_count = 0;
    int n_created = 0;
    int n_full = 0;
    int n_destroyed = 0;
    int n_run_beats = 0;
    int n_found = 0;
    int n_clears = 0;
    int burst_left = 0;
    int gap_left = 0;

    function automatic logic is_live(input logic [7:0] v);
        return v < NSLOTS;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_active[i] = 1'b0;
            tbl_tag[i] = '0;
            tbl_prio[i] = 8'hFF;
            tbl_prev[i] = HEAD_MARK;
            tbl_next[i] = TAIL_MARK;
        end
        tbl_head = EMPTY_MARK;
    endfunction

    // Insert slot n before the first task with a strictly larger priority value.
    function automatic void link_slot(input int n);
        logic [7:0] cur;
        logic [7:0] p;
        cur = tbl_head;
        if (!is_live(cur)) begin
            tbl_prev[n] = HEAD_MARK;
            tbl_next[n] = TAIL_MARK;
            tbl_head = 8'(n);
            return;
        end
        for (int steps = 0; steps < NSLOTS; steps++) begin
            if (tbl_prio[n] < tbl_prio[cur]) begin
                p = tbl_prev[cur];
                tbl_prev[n] = p;
                tbl_next[n] = cur;
                if (is_live(p))
                    tbl_next[p] = 8'(n);
                else
                    tbl_head = 8'(n);
                tbl_prev[cur] = 8'(n);
                return;
            end
            if (!is_live(tbl_next[cur]))
                break;
            cur = tbl_next[cur];
        end
        tbl_prev[n] = cur;
        tbl_next[n] = TAIL_MARK;
        tbl_next[cur] = 8'(n);
    endfunction

    function automatic void unlink_slot(input int s);
        logic [7:0] p;
        logic [7:0] n;
        p = tbl_prev[s];
        n = tbl_next[s];
        if (is_live(p))
            tbl_next[p] = is_live(n) ? n : TAIL_MARK;
        else
            tbl_head = is_live(n) ? n : EMPTY_MARK;
        if (is_live(n))
            tbl_prev[n] = is_live(p) ? p : HEAD_MARK;
    endfunction

    // Update the shadow table for one accepted command and queue the beats it owes.
    function automatic void apply_command(input t_cmd c);
        t_res r;
        logic [7:0] cur;
        logic [7:0] nx;
        int k;
        int hit;
        r = '0;
        r.last = 1'b1;
        hit = -1;
        case (c.mode)
            MODE_CLEAR: begin
                clear_table();
                r.ok = 1'b1;
                n_clears++;
                awaited_beats.push_back(r);
            end
            MODE_CREATE: begin
                for (k = 0; k < NSLOTS; k++)
                    if (!tbl_active[k] && hit < 0)
                        hit = k;
                if (hit >= 0) begin
                    tbl_tag[hit] = c.handler;
                    tbl_prio[hit] = c.priority_req;
                    link_slot(hit);
                    tbl_active[hit] = 1'b1;
                    r.result_slot = hit[3:0];
                    r.result_handler = c.handler;
                    r.ok = 1'b1;
                    n_created++;
                end else begin
                    n_full++;
                end
                awaited_beats.push_back(r);
            end
            MODE_DESTROY: begin
                r.result_slot = c.slot;
                if (tbl_active[c.slot]) begin
                    tbl_active[c.slot] = 1'b0;
                    unlink_slot(int'(c.slot));
                    r.result_handler = tbl_tag[c.slot];
                    r.ok = 1'b1;
                    n_destroyed++;
                end
                awaited_beats.push_back(r);
            end
            MODE_RUN: begin
                cur = tbl_head;
                k = 0;
                while (is_live(cur) && k < RUN_MAX && k < NSLOTS) begin
                    nx = tbl_next[cur];
                    r.result_slot = cur[3:0];
                    r.result_handler = tbl_tag[cur];
                    r.ok = 1'b1;
                    r.last = !is_live(nx) || (k + 1 == RUN_MAX) || (k + 1 == NSLOTS);
                    awaited_beats.push_back(r);
                    n_run_beats++;
                    k++;
                    cur = nx;
                end
                if (k == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    awaited_beats.push_back(r);
                end
            end
            MODE_FIND: begin
                for (k = 0; k < NSLOTS; k++)
                    if (tbl_active[k] && tbl_tag[k] == c.handler && hit < 0)
                        hit = k;
                if (hit >= 0) begin
                    r.result_slot = hit[3:0];
                    r.result_handler = c.handler;
                    r.ok = 1'b1;
                    n_found++;
                end
                awaited_beats.push_back(r);
            end
            default: begin
                awaited_beats.push_back(r);
            end
        endcase
    endfunction

    task automatic queue_cmd(input logic [2:0] mode, input logic [3:0] slot,
                             input logic [15:0] handler, input logic [7:0] prio);
        t_cmd c;
        c.mode = mode;
        c.slot = slot;
        c.handler = handler;
        c.priority_req = prio;
        pending_cmds.push_back(c);
        cmds_total++;
    endtask

    // Driver: presents queued commands in bursts separated by random gaps.
    always @(posedge i_clk) begin : drive_proc
        logic take;
        take = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cmd <= '0;
        end else begin
            if (take) begin
                apply_command(i_cmd);
                cmds_taken++;
            end
            if (take || !start) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    start <= 1'b1;
                    i_cmd <= pending_cmds.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every result beat must match the oldest awaited beat.
    always @(posedge i_clk) begin : check_proc
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            if (awaited_beats.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got slot=%0d handler=%h ok=%b last=%b",
                         $time, o_res.result_slot, o_res.result_handler, o_res.ok, o_res.last);
                error_count++;
            end else begin
                want = awaited_beats.pop_front();
                if (o_res.result_slot !== want.result_slot ||
                    o_res.result_handler !== want.result_handler ||
                    o_res.ok !== want.ok || o_res.last !== want.last) begin
                    $display("%0t: result mismatch: expected slot=%0d handler=%h ok=%b last=%b, got slot=%0d handler=%h ok=%b last=%b",
                             $time, want.result_slot, want.result_handler, want.ok, want.last,
                             o_res.result_slot, o_res.result_handler, o_res.ok, o_res.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("%0t: timed out with %0d commands taken and %0d beats awaited",
                 $time, cmds_taken, awaited_beats.size());
        $display("[priority_ordered_task_table_top] ERROR");
        $finish;
    end

    // Stimulus: directed corners first, then random command mixes.
    initial begin : stim_proc
        logic [7:0] fill_prio [NSLOTS];
        logic [15:0] tag_pool [8];
        int pick;
        logic [2:0] mode;
        logic [15:0] tag;
        logic [7:0] prio;

        fill_prio = '{8'h80, 8'h80, 8'h00, 8'hFF, 8'h80, 8'h40, 8'hFF, 8'h00,
                      8'h7F, 8'h01, 8'hFE, 8'h80, 8'h40, 8'hC0, 8'h00, 8'hFF};
        tag_pool = '{16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5, 16'h5A5A, 16'h0001,
                     16'h8000, 16'h00FF};
        clear_table();

        // Empty table: run order, find and destroy all come back empty.
        queue_cmd(MODE_CLEAR, 4'd0, 16'h0000, 8'h00);
        queue_cmd(MODE_RUN, 4'd0, 16'h0000, 8'h00);
        queue_cmd(MODE_FIND, 4'd0, 16'h0000, 8'h00);
        queue_cmd(MODE_DESTROY, 4'd9, 16'hFFFF, 8'hFF);

        // Fill every slot with ties, new heads and new tails, then overflow.
        for (int i = 0; i < NSLOTS; i++)
            queue_cmd(MODE_CREATE, 4'(i), (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 :
                      16'h5A00 + 16'(i), fill_prio[i]);
        queue_cmd(MODE_CREATE, 4'd15, 16'hBEEF, 8'h00);
        queue_cmd(MODE_RUN, 4'd15, 16'hFFFF, 8'hFF);
        queue_cmd(MODE_FIND, 4'd0, 16'h0000, 8'h00);

        // Destroy the head, another slot, then the head slot again once it is free.
        queue_cmd(MODE_DESTROY, 4'd2, 16'h0000, 8'h00);
        queue_cmd(MODE_DESTROY, 4'd15, 16'h0000, 8'h00);
        queue_cmd(MODE_DESTROY, 4'd2, 16'h0000, 8'h00);
        queue_cmd(MODE_SPARE_LO, 4'd3, 16'h1234, 8'h12);
        queue_cmd(MODE_SPARE_HI, 4'd15, 16'hFFFF, 8'hFF);
        queue_cmd(MODE_RUN, 4'd0, 16'h0000, 8'h00);

        // Random part: creates dominate so the table often runs full.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            pick = $urandom_range(99);
            tag = ($urandom_range(3) == 0) ? 16'($urandom) : tag_pool[$urandom_range(7)];
            prio = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(3) * 8'h55);
            if (pick < 40)
                mode = MODE_CREATE;
            else if (pick < 65)
                mode = MODE_DESTROY;
            else if (pick < 78)
                mode = MODE_RUN;
            else if (pick < 92)
                mode = MODE_FIND;
            else if (pick < 95)
                mode = MODE_CLEAR;
            else
                mode = 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
            queue_cmd(mode, 4'($urandom_range(15)), tag, prio);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_taken < cmds_total || awaited_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: %0d creates placed, %0d rejected on a full table, %0d clears.",
                 cmds_taken, n_created, n_full, n_clears);
        $display("Destroyed %0d live slots, matched %0d finds, checked %0d run-order beats.",
                 n_destroyed, n_found, n_run_beats);
        if (error_count == 0) begin
            $display("[priority_ordered_task_table_top] OK");
        end else begin
            $display("[priority_ordered_task_table_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- priority_ordered_task_table_top.f -----
rtl/core/pott_pkg.sv
rtl/core/pott_ram.sv
rtl/core/priority_ordered_task_table_top.sv
dv/priority_ordered_task_table_top_tb.sv
